/* hdl/fhp_pkg.sv */
// ----------------------------------------------------------------------------
// fhp_pkg
// types and constants shared by the fragment header parser
// ----------------------------------------------------------------------------
`default_nettype none

package fhp_pkg;

  typedef enum logic [2:0] {
    CLS_TOTAL  = 3'd0,
    CLS_FRAGNO = 3'd1,
    CLS_SIZE   = 3'd2,
    CLS_NAME   = 3'd3,
    CLS_DELIM  = 3'd4,
    CLS_KEPT   = 3'd5,
    CLS_DROP   = 3'd6
  } byte_class_e;

  localparam logic [2:0]  POS_TOTAL   = 3'd0;
  localparam logic [2:0]  POS_FRAGNO  = 3'd1;
  localparam logic [2:0]  POS_SIZE    = 3'd2;
  localparam logic [2:0]  POS_NAME    = 3'd3;
  localparam logic [2:0]  POS_PAYLOAD = 3'd4;

  localparam logic [7:0]  DelimChar = 8'h3A;
  localparam logic [7:0]  DigitLo   = 8'h30;
  localparam logic [7:0]  DigitHi   = 8'h39;
  localparam logic [15:0] NumSat    = 16'hFFFF;
  localparam logic [10:0] CountSat  = 11'd2047;

  localparam int unsigned DataW = 72;

endpackage

`default_nettype wire

/* hdl/fragment_header_parser.sv */
// ----------------------------------------------------------------------------
// fragment_header_parser
// byte-wise parser for "total:fragno:size:name:payload" transfer packets
// ----------------------------------------------------------------------------
// Bytes enter on the s_axis channel, one per word; tuser high marks the first
// byte of a packet and clears the parse state before that byte is used.
// Every byte gives exactly one word on m_axis: the byte's class in tuser and,
// in tdata, the echoed byte, the payload index, the three header values as
// parsed so far and the header-done flag.
// The parse state is updated in the cycle a byte is accepted, and the result
// sits in the output register from the next cycle.
// Throughput is one byte per cycle; the single output register is refilled in
// the same cycle it is taken, so s_axis_tready stays high unless the output
// holds a word that m_axis_tready has not taken.
// While the receiver stalls the output word holds and no new byte is taken.
// Reset clears the parse state and empties the output register.
// PAYLOAD_MAX bounds how many payload bytes are marked as kept.
// ----------------------------------------------------------------------------
`default_nettype none

module fragment_header_parser #(
  parameter int unsigned PAYLOAD_MAX = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] data_byte
  input  wire logic [7:0]                   s_axis_tdata,
  // [0] packet_start
  input  wire logic                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [7:0] out_byte, [17:8] payload_index, [33:18] total_count,
  // [49:34] fragment_number, [65:50] payload_size, [66] header_done
  output logic [fhp_pkg::DataW-1:0]         m_axis_tdata,
  // [2:0] byte_class
  output logic [2:0]                        m_axis_tuser
);

  logic [2:0]  field_pos_q, field_pos_d, pos_b;
  logic [15:0] total_q, total_d, total_b;
  logic [15:0] fragno_q, fragno_d, fragno_b;
  logic [15:0] size_q, size_d, size_b;
  logic [2:0]  frozen_q, frozen_d, frozen_b;
  logic [10:0] pcount_q, pcount_d, pcount_b;

  logic        out_valid_q;
  logic [fhp_pkg::DataW-1:0] out_data_q, out_data_d;
  fhp_pkg::byte_class_e out_class_q, out_class_d;

  logic        accept;
  logic        is_delim, is_digit;
  logic [3:0]  digit;
  logic [15:0] acc_sel, acc_new;
  logic [19:0] acc_mul;
  logic [9:0]  pidx;
  logic        keep;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign is_delim = (s_axis_tdata == fhp_pkg::DelimChar);
  assign is_digit = (s_axis_tdata >= fhp_pkg::DigitLo) && (s_axis_tdata <= fhp_pkg::DigitHi);
  assign digit    = 4'(s_axis_tdata - fhp_pkg::DigitLo);

  // state as seen by this byte, cleared on packet start
  always_comb begin
    if (s_axis_tuser) begin
      pos_b    = '0;
      total_b  = '0;
      fragno_b = '0;
      size_b   = '0;
      frozen_b = '0;
      pcount_b = '0;
    end else begin
      pos_b    = field_pos_q;
      total_b  = total_q;
      fragno_b = fragno_q;
      size_b   = size_q;
      frozen_b = frozen_q;
      pcount_b = pcount_q;
    end
  end

  // value * 10 + digit, saturating
  always_comb begin
    case (pos_b)
      fhp_pkg::POS_TOTAL:  acc_sel = total_b;
      fhp_pkg::POS_FRAGNO: acc_sel = fragno_b;
      default:             acc_sel = size_b;
    endcase
    acc_mul = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + {16'd0, digit};
    acc_new = (acc_mul > {4'd0, fhp_pkg::NumSat}) ? fhp_pkg::NumSat : acc_mul[15:0];
  end

  assign keep = (pcount_b < fhp_pkg::CountSat) && ({5'd0, pcount_b} < size_b)
             && ({21'd0, pcount_b} < 32'(PAYLOAD_MAX));

  always_comb begin
    field_pos_d = pos_b;
    total_d     = total_b;
    fragno_d    = fragno_b;
    size_d      = size_b;
    frozen_d    = frozen_b;
    pcount_d    = pcount_b;
    pidx        = '0;
    out_class_d = fhp_pkg::CLS_NAME;
    if (pos_b < fhp_pkg::POS_NAME) begin
      if (is_delim) begin
        out_class_d = fhp_pkg::CLS_DELIM;
        field_pos_d = pos_b + 3'd1;
      end else begin
        out_class_d = fhp_pkg::byte_class_e'(pos_b);
        if (is_digit && !frozen_b[pos_b[1:0]]) begin
          case (pos_b)
            fhp_pkg::POS_TOTAL:  total_d  = acc_new;
            fhp_pkg::POS_FRAGNO: fragno_d = acc_new;
            default:             size_d   = acc_new;
          endcase
        end else begin
          frozen_d[pos_b[1:0]] = 1'b1;
        end
      end
    end else if (pos_b == fhp_pkg::POS_NAME) begin
      if (is_delim) begin
        out_class_d = fhp_pkg::CLS_DELIM;
        field_pos_d = fhp_pkg::POS_PAYLOAD;
      end else begin
        out_class_d = fhp_pkg::CLS_NAME;
      end
    end else begin
      if (keep) begin
        out_class_d = fhp_pkg::CLS_KEPT;
        pidx        = pcount_b[9:0];
      end else begin
        out_class_d = fhp_pkg::CLS_DROP;
      end
      if (pcount_b < fhp_pkg::CountSat) begin
        pcount_d = pcount_b + 11'd1;
      end
    end
    out_data_d = {5'd0, (field_pos_d >= fhp_pkg::POS_PAYLOAD), size_d, fragno_d, total_d,
                  pidx, s_axis_tdata};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_pos_q <= '0;
      total_q     <= '0;
      fragno_q    <= '0;
      size_q      <= '0;
      frozen_q    <= '0;
      pcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        field_pos_q <= field_pos_d;
        total_q     <= total_d;
        fragno_q    <= fragno_d;
        size_q      <= size_d;
        frozen_q    <= frozen_d;
        pcount_q    <= pcount_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q  <= out_data_d;
      out_class_q <= out_class_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_class_q;

  // kept payload index stays below the parsed size
  a_kept_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == fhp_pkg::CLS_KEPT))
      |-> ({6'd0, m_axis_tdata[17:8]} < m_axis_tdata[65:50]))
    else $error("kept payload index not below payload size");

  // payload classes only after the header is done
  a_payload_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser == fhp_pkg::CLS_KEPT) ||
                       (m_axis_tuser == fhp_pkg::CLS_DROP)))
      |-> m_axis_tdata[66])
    else $error("payload byte before header done");

  // once done, only delimiter or payload classes appear
  a_done_classes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[66])
      |-> ((m_axis_tuser == fhp_pkg::CLS_DELIM) || (m_axis_tuser == fhp_pkg::CLS_KEPT) ||
           (m_axis_tuser == fhp_pkg::CLS_DROP)))
    else $error("header field class after header done");

  // a frozen total field stays frozen within a packet
  a_frozen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !s_axis_tuser && frozen_q[0]) |=> frozen_q[0])
    else $error("frozen total field thawed without packet start");

endmodule

`default_nettype wire
